### design/fgpd_pkg.sv
package fgpd_pkg;
  localparam logic [2:0] REG_KP = 3'd0;
  localparam logic [2:0] REG_KD = 3'd1;
  localparam logic [2:0] REG_EB = 3'd2;
  localparam logic [2:0] REG_CB = 3'd3;
  localparam logic [2:0] REG_KPA = 3'd4;
  localparam logic [2:0] REG_KDA = 3'd5;

  // rule level minus 3, signed 4 bit
  function automatic logic signed [3:0] kp_rule(input logic [2:0] r, input logic [2:0] c);
    logic [2:0] t [49];
    t = '{3'd6,3'd5,3'd5,3'd4,3'd4,3'd3,3'd2, 3'd5,3'd5,3'd4,3'd4,3'd3,3'd2,3'd1,
          3'd4,3'd4,3'd4,3'd4,3'd2,3'd1,3'd0, 3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,
          3'd0,3'd1,3'd2,3'd4,3'd4,3'd4,3'd4, 3'd1,3'd2,3'd3,3'd4,3'd4,3'd5,3'd5,
          3'd2,3'd3,3'd4,3'd4,3'd5,3'd5,3'd6};
    return $signed({1'b0, t[6'(r) * 6'd7 + 6'(c)]}) - 4'sd3;
  endfunction

  function automatic logic signed [3:0] kd_rule(input logic [2:0] r, input logic [2:0] c);
    logic [2:0] t [49];
    t = '{3'd6,3'd5,3'd4,3'd3,3'd4,3'd5,3'd6, 3'd5,3'd4,3'd3,3'd2,3'd3,3'd4,3'd5,
          3'd4,3'd3,3'd2,3'd1,3'd2,3'd3,3'd4, 3'd3,3'd2,3'd1,3'd0,3'd1,3'd2,3'd3,
          3'd4,3'd3,3'd2,3'd1,3'd2,3'd3,3'd4, 3'd5,3'd4,3'd3,3'd2,3'd3,3'd4,3'd5,
          3'd6,3'd5,3'd4,3'd3,3'd4,3'd5,3'd6};
    return $signed({1'b0, t[6'(r) * 6'd7 + 6'(c)]}) - 4'sd3;
  endfunction
endpackage

### design/fgpd_if.sv
interface fgpd_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] error_sample;
  modport source (output valid, output error_sample, input ready);
  modport sink (input valid, input error_sample, output ready);
endinterface

interface fgpd_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] drive;
  logic drive_saturated;
  modport source (output valid, output drive, output drive_saturated, input ready);
  modport sink (input valid, input drive, input drive_saturated, output ready);
endinterface

### design/fuzzy_gain_pd_controller_core.sv
// An item passes through segment search, the error and change weights, the blend, the two
// gain divisions and the two multiply steps; a weight that clamps skips its division, so an
// item makes two to four passes through the 49-step bit-serial divider.
// Items are taken one at a time; the next item is taken in the idle state once the
// previous result is being taken or has been taken.
// Reset (rst_n low, synchronous) restores register defaults, clears previous error.
module fuzzy_gain_pd_controller_core (
  input logic clk,
  input logic rst_n,
  fgpd_in_if.sink    in_ch,
  fgpd_out_if.source out_ch,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_wdata
);
  import fgpd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_SEG = 4'd1, S_DE = 4'd2, S_WE = 4'd3,
                         S_DC = 4'd4, S_WC = 4'd5, S_BL = 4'd6, S_DP = 4'd7,
                         S_WP = 4'd8, S_DD = 4'd9, S_WD = 4'd10, S_M1 = 4'd11,
                         S_M2 = 4'd12, S_OUT = 4'd13;

  logic signed [31:0] kp_r, kd_r;
  logic [30:0] eb_r, cb_r, kpa_r, kda_r;
  logic signed [31:0] prev_r, e_r;
  logic signed [32:0] c_r;
  logic [3:0] st_r;
  logic [2:0] le_r, lc_r;
  logic [16:0] wre_r, wrc_r;
  logic signed [19:0] mp_r, md_r;
  logic signed [33:0] gp_r, gd_r;
  logic signed [66:0] acc_r;
  logic signed [31:0] drv_r;
  logic sat_r, ov_r;
  logic neg_r;

  logic [30:0] ebx, cbx;
  assign ebx = (eb_r == '0) ? 31'd1 : eb_r;
  assign cbx = (cb_r == '0) ? 31'd1 : cb_r;

  // segment search: 5 independent compares
  function automatic logic [2:0] find_left(input logic signed [32:0] x,
                                           input logic [30:0] b);
    logic signed [35:0] x3;
    logic [2:0] l;
    x3 = 36'(x) * 36'sd3;
    l = 3'd5;
    for (int i = 5; i >= 1; i--) begin
      if (x3 < 36'(i - 3) * $signed({5'd0, b})) l = 3'(i - 1);
    end
    return l;
  endfunction

  function automatic logic signed [36:0] wnum(input logic signed [32:0] x,
                                              input logic [30:0] b, input logic [2:0] l);
    return 37'(x) * 37'sd3 - $signed({4'd0, 3'(l)} - 7'sd3) * $signed({6'd0, b});
  endfunction

  logic signed [36:0] nume, numc;
  logic signed [32:0] csamp;
  assign csamp = 33'(in_ch.error_sample) - 33'(prev_r);
  assign nume = wnum(33'(e_r), ebx, le_r);
  assign numc = wnum(c_r, cbx, lc_r);

  // shared divider
  logic dv_start, dv_done;
  logic [48:0] dv_num, dv_quo;
  logic [32:0] dv_den;
  fgpd_serdiv u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num),
                     .den(dv_den), .done(dv_done), .quo(dv_quo));

  // blend terms
  logic signed [17:0] wle, wlc, wres, wrcs;
  logic signed [39:0] blp, bld;
  assign wle = 18'sd65536 - $signed({1'b0, wre_r});
  assign wlc = 18'sd65536 - $signed({1'b0, wrc_r});
  assign wres = $signed({1'b0, wre_r});
  assign wrcs = $signed({1'b0, wrc_r});
  always_comb begin
    blp = 40'(wle * wlc) * 40'(kp_rule(le_r, lc_r))
        + 40'(wle * wrcs) * 40'(kp_rule(le_r, lc_r + 3'd1))
        + 40'(wres * wlc) * 40'(kp_rule(le_r + 3'd1, lc_r))
        + 40'(wres * wrcs) * 40'(kp_rule(le_r + 3'd1, lc_r + 3'd1));
    bld = 40'(wle * wlc) * 40'(kd_rule(le_r, lc_r))
        + 40'(wle * wrcs) * 40'(kd_rule(le_r, lc_r + 3'd1))
        + 40'(wres * wlc) * 40'(kd_rule(le_r + 3'd1, lc_r))
        + 40'(wres * wrcs) * 40'(kd_rule(le_r + 3'd1, lc_r + 3'd1));
  end

  logic signed [50:0] mkp, mkd;
  logic [49:0] mag_p, mag_d;
  assign mkp = 51'(mp_r) * $signed({20'd0, kpa_r});
  assign mkd = 51'(md_r) * $signed({20'd0, kda_r});
  assign mag_p = mkp[50] ? 50'(-mkp) : 50'(mkp);
  assign mag_d = mkd[50] ? 50'(-mkd) : 50'(mkd);

  logic signed [66:0] sh_acc;
  assign sh_acc = acc_r >>> 16;

  logic dv_exact;
  logic [49:0] mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 32'sd65536; kd_r <= '0; eb_r <= 31'd65536; cb_r <= 31'd65536;
      kpa_r <= '0; kda_r <= '0; prev_r <= '0; st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP: kp_r <= cfg_wdata;
          REG_KD: kd_r <= cfg_wdata;
          REG_EB: eb_r <= cfg_wdata[30:0];
          REG_CB: cb_r <= cfg_wdata[30:0];
          REG_KPA: kpa_r <= cfg_wdata[30:0];
          REG_KDA: kda_r <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (st_r == S_OUT) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid && (!ov_r || out_ch.ready)) begin
          e_r <= in_ch.error_sample;
          c_r <= csamp;
          prev_r <= in_ch.error_sample;
          st_r <= S_SEG;
        end
        S_SEG: begin
          le_r <= find_left(33'(e_r), ebx);
          lc_r <= find_left(c_r, cbx);
          st_r <= S_DE;
        end
        S_DE: begin
          if (nume <= 0) begin wre_r <= '0; st_r <= S_DC; end
          else if (nume >= $signed({6'd0, ebx})) begin wre_r <= 17'd65536; st_r <= S_DC; end
          else st_r <= S_WE;
        end
        S_WE: if (dv_done) begin wre_r <= dv_quo[16:0]; st_r <= S_DC; end
        S_DC: begin
          if (numc <= 0) begin wrc_r <= '0; st_r <= S_BL; end
          else if (numc >= $signed({6'd0, cbx})) begin wrc_r <= 17'd65536; st_r <= S_BL; end
          else st_r <= S_WC;
        end
        S_WC: if (dv_done) begin wrc_r <= dv_quo[16:0]; st_r <= S_BL; end
        S_BL: begin
          mp_r <= 20'(blp >>> 16);
          md_r <= 20'(bld >>> 16);
          st_r <= S_DP;
        end
        S_DP: begin neg_r <= mkp[50]; mag_r <= mag_p; st_r <= S_WP; end
        S_WP: if (dv_done) begin
          gp_r <= 34'(kp_r) + (neg_r ? -34'(dv_quo) - 34'(!dv_exact) : 34'(dv_quo));
          st_r <= S_DD;
        end
        S_DD: begin neg_r <= mkd[50]; mag_r <= mag_d; st_r <= S_WD; end
        S_WD: if (dv_done) begin
          gd_r <= 34'(kd_r) + (neg_r ? -34'(dv_quo) - 34'(!dv_exact) : 34'(dv_quo));
          st_r <= S_M1;
        end
        S_M1: begin acc_r <= 67'(gp_r) * 67'(e_r); st_r <= S_M2; end
        S_M2: begin acc_r <= acc_r + 67'(gd_r) * 67'(c_r); st_r <= S_OUT; end
        S_OUT: begin
          if (sh_acc > 67'sd2147483647) begin drv_r <= 32'h7FFFFFFF; sat_r <= 1'b1; end
          else if (sh_acc < -67'sd2147483648) begin drv_r <= 32'h80000000; sat_r <= 1'b1; end
          else begin drv_r <= sh_acc[31:0]; sat_r <= 1'b0; end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // floor of a negative quotient is -ceil(|n|/d): one more when the division is not exact
  assign dv_exact = (51'(dv_quo) * 51'd196608) == 51'(mag_r);

  always_comb begin
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = '0;
    case (st_r)
      S_DE: begin
        dv_start = (nume > 0) && (nume < $signed({6'd0, ebx}));
        dv_num = {nume[32:0], 16'd0};
        dv_den = {2'd0, ebx};
      end
      S_DC: begin
        dv_start = (numc > 0) && (numc < $signed({6'd0, cbx}));
        dv_num = {numc[32:0], 16'd0};
        dv_den = {2'd0, cbx};
      end
      S_DP: begin
        dv_start = 1'b1;
        dv_num = mag_p[48:0];
        dv_den = 33'd196608;
      end
      S_DD: begin
        dv_start = 1'b1;
        dv_num = mag_d[48:0];
        dv_den = 33'd196608;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (st_r == S_IDLE) && (!ov_r || out_ch.ready);
  assign out_ch.valid = ov_r;
  assign out_ch.drive = drv_r;
  assign out_ch.drive_saturated = sat_r;

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |=> out_ch.valid) else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.drive)) else $error("drive moved");
endmodule

### design/fgpd_serdiv.sv
// Bit-serial restoring divider: quotient = floor(num / den), num < 2^49, den < 2^33.
module fgpd_serdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [48:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [48:0] quo
);
  logic [48:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [33:0] sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r, q_r[48]};
    if (start) begin
      q_nxt = num; rem_nxt = '0; den_nxt = den; cnt_nxt = 6'd49; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = 33'(sh - {1'b0, den_r});
        q_nxt = {q_r[47:0], 1'b1};
      end else begin
        rem_nxt = sh[32:0];
        q_nxt = {q_r[47:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule
